### hw/rtl/dual_motor_frame_crc8_encoder_core_assert.svh
// Assertion macros for the frame encoder RTL; used by dmfc_frame_ser.
// Needs nothing else; the checks vanish when SYNTH is defined.
`ifndef DUAL_MOTOR_FRAME_CRC8_ENCODER_CORE_ASSERT_SVH
`define DUAL_MOTOR_FRAME_CRC8_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTH
// Check that a condition holds at every clock edge outside reset.
`define DMFC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("dmfc assertion failed");
// Check that a trigger is followed in the next cycle by an outcome.
`define DMFC_ASSERT_NEXT(label, clk, rst, trig, outcome) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (outcome)) \
      else $error("dmfc assertion failed");
`else
`define DMFC_ASSERT_ALWAYS(label, clk, rst, cond)
`define DMFC_ASSERT_NEXT(label, clk, rst, trig, outcome)
`endif
`endif

### hw/rtl/dmfc_pkg.sv
// Types, frame constants and CRC-8/Maxim step for the frame encoder.
// Depends on nothing; used by every module of the block.
`default_nettype none
package dmfc_pkg;

   typedef struct packed {
      logic [7:0]  first_motor_id;
      logic [31:0] first_speed_bits;
      logic [7:0]  second_motor_id;
      logic [31:0] second_speed_bits;
   } dmfc_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_frame;
   } dmfc_rsp_type;

   localparam int unsigned FRAME_LEN = 23;
   localparam int unsigned POS_W     = $clog2(FRAME_LEN);

   typedef logic [POS_W-1:0] dmfc_pos_type;

   // byte positions within the frame
   localparam dmfc_pos_type POS_HDR0   = POS_W'(0);
   localparam dmfc_pos_type POS_HDR1   = POS_W'(1);
   localparam dmfc_pos_type POS_LEAD0  = POS_W'(2);
   localparam dmfc_pos_type POS_LEAD1  = POS_W'(3);
   localparam dmfc_pos_type POS_LEAD2  = POS_W'(4);
   localparam dmfc_pos_type POS_LEAD3  = POS_W'(5);
   localparam dmfc_pos_type POS_ID1    = POS_W'(6);
   localparam dmfc_pos_type POS_SPD1_0 = POS_W'(7);
   localparam dmfc_pos_type POS_SPD1_1 = POS_W'(8);
   localparam dmfc_pos_type POS_SPD1_2 = POS_W'(9);
   localparam dmfc_pos_type POS_SPD1_3 = POS_W'(10);
   localparam dmfc_pos_type POS_ID2    = POS_W'(11);
   localparam dmfc_pos_type POS_SPD2_0 = POS_W'(12);
   localparam dmfc_pos_type POS_SPD2_1 = POS_W'(13);
   localparam dmfc_pos_type POS_SPD2_2 = POS_W'(14);
   localparam dmfc_pos_type POS_SPD2_3 = POS_W'(15);
   localparam dmfc_pos_type POS_TAIL0  = POS_W'(16);
   localparam dmfc_pos_type POS_TAIL1  = POS_W'(17);
   localparam dmfc_pos_type POS_TAIL2  = POS_W'(18);
   localparam dmfc_pos_type POS_TAIL3  = POS_W'(19);
   localparam dmfc_pos_type POS_TAIL4  = POS_W'(20);
   localparam dmfc_pos_type POS_TAIL5  = POS_W'(21);
   localparam dmfc_pos_type POS_CRC    = POS_W'(22);

   localparam logic [7:0] HDR0  = 8'hAA;
   localparam logic [7:0] HDR1  = 8'h55;
   localparam logic [7:0] LEAD0 = 8'h03;
   localparam logic [7:0] LEAD1 = 8'h12;
   localparam logic [7:0] LEAD2 = 8'h01;
   localparam logic [7:0] LEAD3 = 8'h02;
   localparam logic [7:0] TAIL0 = 8'hF4;
   localparam logic [7:0] TAIL1 = 8'h6B;
   localparam logic [7:0] TAIL2 = 8'h92;
   localparam logic [7:0] TAIL3 = 8'h0A;
   localparam logic [7:0] TAIL4 = 8'h7B;
   localparam logic [7:0] TAIL5 = 8'hD2;

   localparam logic [7:0] CRC_POLY = 8'h8C;  // reflected form
   localparam logic [7:0] CRC_INIT = 8'h00;

   // one byte through the reflected CRC-8/Maxim, bit by bit
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // body byte at a position; the CRC position is supplied elsewhere
   function automatic logic [7:0] body_byte(input dmfc_req_type item, input dmfc_pos_type pos);
      logic [7:0] b;
      unique case (pos)
         POS_HDR0:   b = HDR0;
         POS_HDR1:   b = HDR1;
         POS_LEAD0:  b = LEAD0;
         POS_LEAD1:  b = LEAD1;
         POS_LEAD2:  b = LEAD2;
         POS_LEAD3:  b = LEAD3;
         POS_ID1:    b = item.first_motor_id;
         POS_SPD1_0: b = item.first_speed_bits[7:0];
         POS_SPD1_1: b = item.first_speed_bits[15:8];
         POS_SPD1_2: b = item.first_speed_bits[23:16];
         POS_SPD1_3: b = item.first_speed_bits[31:24];
         POS_ID2:    b = item.second_motor_id;
         POS_SPD2_0: b = item.second_speed_bits[7:0];
         POS_SPD2_1: b = item.second_speed_bits[15:8];
         POS_SPD2_2: b = item.second_speed_bits[23:16];
         POS_SPD2_3: b = item.second_speed_bits[31:24];
         POS_TAIL0:  b = TAIL0;
         POS_TAIL1:  b = TAIL1;
         POS_TAIL2:  b = TAIL2;
         POS_TAIL3:  b = TAIL3;
         POS_TAIL4:  b = TAIL4;
         POS_TAIL5:  b = TAIL5;
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/dmfc_in_reg.sv
// Input holding register: one request beat waits here for the serialiser.
// Depends on dmfc_pkg.
`default_nettype none
module dmfc_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dmfc_pkg::dmfc_req_type req_data,
   output logic                       item_valid,
   output dmfc_pkg::dmfc_req_type     item,
   input  wire logic                  item_take
);
   import dmfc_pkg::*;

   logic         item_valid_ff, item_valid_in;
   dmfc_req_type item_ff, item_in;

   // take a new beat when empty or when the held one leaves this cycle
   assign req_ready = !item_valid_ff || item_take;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
         item_in       = req_data;
      end else if (item_take) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

### hw/rtl/dmfc_frame_ser.sv
// Frame serialiser: byte counter, running CRC and the result register.
// Depends on dmfc_pkg and the assertion macro header.
`default_nettype none
`include "dual_motor_frame_crc8_encoder_core_assert.svh"
module dmfc_frame_ser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire dmfc_pkg::dmfc_req_type item,
   output logic                       item_take,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dmfc_pkg::dmfc_rsp_type     rsp_data
);
   import dmfc_pkg::*;

   logic         active_ff, active_in;
   dmfc_pos_type pos_ff, pos_in;
   dmfc_req_type frame_ff, frame_in;
   logic [7:0]   crc_ff, crc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   dmfc_rsp_type rsp_ff, rsp_in;

   logic       advance;
   logic       at_last;
   logic       in_body;
   logic [7:0] cur_byte;

   assign advance  = active_ff && (!rsp_valid_ff || rsp_ready);
   assign at_last  = (pos_ff == POS_CRC);
   assign in_body  = (pos_ff >= POS_LEAD0) && (pos_ff <= POS_TAIL5);
   assign cur_byte = at_last ? crc_ff : body_byte(frame_ff, pos_ff);

   // load the next item when idle or as the CRC byte goes out
   assign item_take = item_valid && (!active_ff || (advance && at_last));

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      frame_in  = frame_ff;
      crc_in    = crc_ff;
      if (item_take) begin
         active_in = 1'b1;
         pos_in    = POS_HDR0;
         frame_in  = item;
         crc_in    = CRC_INIT;
      end else if (advance) begin
         if (at_last) begin
            active_in = 1'b0;
            pos_in    = POS_HDR0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (in_body) begin
               crc_in = crc8_step(crc_ff, cur_byte);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in         = 1'b1;
         rsp_in.frame_byte    = cur_byte;
         rsp_in.last_of_frame = at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= POS_HDR0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      crc_ff   <= crc_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DMFC_ASSERT_ALWAYS(a_pos_in_range, clock, reset, pos_ff <= POS_CRC)
   `DMFC_ASSERT_ALWAYS(a_idle_pos_zero, clock, reset, active_ff || (pos_ff == POS_HDR0))
   `DMFC_ASSERT_NEXT(a_crc_marks_last, clock, reset, advance && at_last,
                     rsp_valid_ff && rsp_ff.last_of_frame)
   `DMFC_ASSERT_NEXT(a_body_not_last, clock, reset, advance && !at_last,
                     rsp_valid_ff && !rsp_ff.last_of_frame)

endmodule
`default_nettype wire

### hw/rtl/dual_motor_frame_crc8_encoder_core.sv
// Top level of the dual motor frame encoder with CRC-8/Maxim check byte.
// Depends on dmfc_pkg, dmfc_in_reg and dmfc_frame_ser.
//
// Usage:
//   Request channel (req_valid/req_ready/req_data): one beat carries two
//   motor IDs and two raw 32-bit speed patterns.
//   Response channel (rsp_valid/rsp_ready/rsp_data): 23 beats per request,
//   one frame byte each: AA 55, 03 12 01 02, id1, speed1 (LSB first), id2,
//   speed2 (LSB first), F4 6B 92 0A 7B D2 and the CRC-8/Maxim of the 20
//   bytes after the header. last_of_frame is high on the CRC beat only.
// Path: with the serialiser idle, the first byte of a frame passes through
//   the holding register, the frame register and the response register.
// Throughput: one response beat per cycle while rsp_ready is high. A
//   holding register takes the next request while the current frame
//   streams out, and frames follow each other with no gap.
// Reset: clears the valid flags and byte counter; no beats are in flight
//   afterwards.
// Stall: while rsp_ready is low the response register holds its byte, the
//   counter stops and, once the holding register is full, req_ready drops.
`default_nettype none
module dual_motor_frame_crc8_encoder_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire dmfc_pkg::dmfc_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output dmfc_pkg::dmfc_rsp_type     rsp_data
);
   import dmfc_pkg::*;

   // hand-over between the holding register and the serialiser
   logic         item_valid;
   dmfc_req_type item;
   logic         item_take;

   // hold one request beat so the next can arrive during a frame
   dmfc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // advance one byte per accepted response beat, folding the CRC as it goes
   dmfc_frame_ser u_frame_ser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for the dual motor frame encoder with CRC-8/Maxim byte.
// Depends on dmfc_pkg and dual_motor_frame_crc8_encoder_core; every beat of
// every 23-byte frame is predicted locally and compared as it is accepted.
module tb_top;
   import dmfc_pkg::*;

   // cycles with no beat on either channel before the run is abandoned
   localparam int WATCHDOG_LIMIT  = 3000;
   // length of the long receiver hold-off used to fill the block
   localparam int HOLD_OFF_CYCLES = 300;
   // items per random phase
   localparam int PHASE_ITEMS     = 70;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   dmfc_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   dmfc_rsp_type rsp_data;

   // commands waiting to be offered, and frame beats still owed by the block
   dmfc_req_type cmd_backlog[$];
   dmfc_rsp_type frame_beats_due[$];

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   logic pressure_go  = 1'b0;
   int  hold_left     = 0;
   int  quiet_cycles  = 0;
   int  fault_count   = 0;

   dual_motor_frame_crc8_encoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Fold one byte into the reflected CRC a bit at a time, LSB first.
   function automatic logic [7:0] crc8_maxim_fold(input logic [7:0] crc,
                                                  input logic [7:0] data);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = acc[0] ^ data[i];
         acc      = {1'b0, acc[7:1]} ^ (feedback ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   // Build the whole frame for one command and queue its beats in send order.
   function automatic void predict_frame(input dmfc_req_type cmd);
      logic [7:0]   frame [FRAME_LEN];
      logic [7:0]   crc;
      dmfc_rsp_type beat;
      frame[POS_HDR0]  = HDR0;
      frame[POS_HDR1]  = HDR1;
      frame[POS_LEAD0] = LEAD0;
      frame[POS_LEAD1] = LEAD1;
      frame[POS_LEAD2] = LEAD2;
      frame[POS_LEAD3] = LEAD3;
      frame[POS_ID1]   = cmd.first_motor_id;
      frame[POS_ID2]   = cmd.second_motor_id;
      // speeds go out least significant byte first
      for (int k = 0; k < 4; k++) begin
         frame[int'(POS_SPD1_0) + k] = cmd.first_speed_bits[8*k +: 8];
         frame[int'(POS_SPD2_0) + k] = cmd.second_speed_bits[8*k +: 8];
      end
      frame[POS_TAIL0] = TAIL0;
      frame[POS_TAIL1] = TAIL1;
      frame[POS_TAIL2] = TAIL2;
      frame[POS_TAIL3] = TAIL3;
      frame[POS_TAIL4] = TAIL4;
      frame[POS_TAIL5] = TAIL5;
      // check byte covers everything after the header
      crc = CRC_INIT;
      for (int k = int'(POS_LEAD0); k < int'(POS_CRC); k++) begin
         crc = crc8_maxim_fold(crc, frame[k]);
      end
      frame[POS_CRC] = crc;
      for (int k = 0; k < int'(FRAME_LEN); k++) begin
         beat.frame_byte    = frame[k];
         beat.last_of_frame = (k == int'(POS_CRC));
         frame_beats_due.push_back(beat);
      end
   endfunction

   task automatic queue_cmd(input logic [7:0] id1, input logic [31:0] spd1,
                            input logic [7:0] id2, input logic [31:0] spd2);
      dmfc_req_type cmd;
      cmd.first_motor_id    = id1;
      cmd.first_speed_bits  = spd1;
      cmd.second_motor_id   = id2;
      cmd.second_speed_bits = spd2;
      cmd_backlog.push_back(cmd);
   endtask

   // Random command; now and then a speed is an IEEE special pattern.
   function automatic dmfc_req_type random_command();
      dmfc_req_type cmd;
      cmd.first_motor_id    = 8'($urandom_range(255));
      cmd.second_motor_id   = 8'($urandom_range(255));
      cmd.first_speed_bits  = $urandom;
      cmd.second_speed_bits = $urandom;
      case ($urandom_range(11))
         0:       cmd.first_speed_bits  = 32'h7FC0_0000 | ($urandom & 32'h003F_FFFF);
         1:       cmd.second_speed_bits = {$urandom_range(1) == 1, 31'h7F80_0000};
         2:       cmd.first_speed_bits  = $urandom & 32'h807F_FFFF;
         default: ;
      endcase
      return cmd;
   endfunction

   task automatic queue_random(input int count);
      repeat (count) cmd_backlog.push_back(random_command());
   endtask

   // Hold until every queued command is taken and every owed beat has come.
   task automatic settle_out();
      do begin
         @(negedge clock);
      end while (cmd_backlog.size() != 0 || req_valid || frame_beats_due.size() != 0);
   endtask

   // Driver: offer the next command when the channel is free, and pick the
   // receiver's readiness each cycle. Each signal gets one update per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // only move on once the current beat has gone, so valid never drops early
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= cmd_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long hold-off on the response side, counted in its own process.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (pressure_go) begin
         hold_left <= HOLD_OFF_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: predict on each accepted command, check each accepted beat.
   always @(posedge clock) begin : monitor
      dmfc_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_frame(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_beats_due.size() == 0) begin
               $display("%0t: unexpected beat, byte %02h last %b", $time,
                        rsp_data.frame_byte, rsp_data.last_of_frame);
               fault_count++;
            end else begin
               want = frame_beats_due.pop_front();
               if (rsp_data.frame_byte !== want.frame_byte) begin
                  $display("%0t: frame_byte expected %02h actual %02h", $time,
                           want.frame_byte, rsp_data.frame_byte);
                  fault_count++;
               end
               if (rsp_data.last_of_frame !== want.last_of_frame) begin
                  $display("%0t: last_of_frame expected %b actual %b", $time,
                           want.last_of_frame, rsp_data.last_of_frame);
                  fault_count++;
               end
            end
         end
      end
   end

   // Watchdog: abandon the run if no beat moves on either side for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // directed commands: field extremes, bit patterns and IEEE specials
      queue_cmd(8'h00, 32'h0000_0000, 8'h00, 32'h0000_0000);
      queue_cmd(8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      queue_cmd(8'h00, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0000);
      queue_cmd(8'hFF, 32'h0000_0000, 8'h00, 32'hFFFF_FFFF);
      queue_cmd(8'h01, 32'h3F80_0000, 8'h02, 32'hBF80_0000);  // +1.0, -1.0
      queue_cmd(8'h7F, 32'h7FC0_0000, 8'h80, 32'hFF80_0000);  // NaN, -inf
      queue_cmd(8'h10, 32'h7F80_0000, 8'h20, 32'h8000_0000);  // +inf, -0
      queue_cmd(8'h55, 32'h0000_0001, 8'hAA, 32'h807F_FFFF);  // denormals
      queue_cmd(8'h80, 32'h7F7F_FFFF, 8'h7F, 32'h0080_0000);  // max, min normal
      queue_cmd(8'hA5, 32'hAAAA_AAAA, 8'h5A, 32'h5555_5555);
      queue_cmd(8'h5A, 32'h5555_5555, 8'hA5, 32'hAAAA_AAAA);
      queue_cmd(8'h0F, 32'h1234_5678, 8'hF0, 32'h89AB_CDEF);
      // then a stretch with no idling on either side
      queue_random(PHASE_ITEMS);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      settle_out();

      // sender mostly idle
      send_idle_pct = 81;
      stall_pct     = 0;
      queue_random(PHASE_ITEMS);
      settle_out();

      // receiver mostly stalling
      send_idle_pct = 0;
      stall_pct     = 81;
      queue_random(PHASE_ITEMS);
      settle_out();

      // both sides idling now and then
      send_idle_pct = 22;
      stall_pct     = 22;
      queue_random(PHASE_ITEMS);
      settle_out();

      // hold the receiver off while the sender keeps pushing, so the
      // holding register fills and the request side backs up
      send_idle_pct = 0;
      stall_pct     = 0;
      pressure_go   = 1'b1;
      queue_random(25);
      @(negedge clock);
      pressure_go   = 1'b0;
      settle_out();

      // allow for any stray beat beyond the last expected one
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
